### src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_OUT       = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CMD_W         = 3;
  localparam int SLOT_W        = 3;
  localparam int PERIOD_W      = 16;

  localparam logic KIND_CREATE   = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_SUSPEND = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t                op;
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } op_entry_t;

  typedef struct packed {
    logic                start;
    logic [PERIOD_W-1:0] dividend;
    logic [PERIOD_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

### src/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd_if
// Request and response channels of the periodic task dispatcher.
// ----------------------------------------------------------------------------
interface ptd_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptd_pkg::CMD_W-1:0]     cmd;
  logic [ptd_pkg::SLOT_W-1:0]    slot;
  logic [ptd_pkg::PERIOD_W-1:0]  period;

  modport source (output valid, output cmd, output slot, output period, input ready);
  modport sink   (input valid, input cmd, input slot, input period, output ready);
endinterface

interface ptd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ptd_pkg::SLOT_W-1:0]    task_index;
  logic                          error;
  logic                          last;

  modport source (output valid, output kind, output task_index, output error,
                  output last, input ready);
  modport sink   (input valid, input kind, input task_index, input error,
                  input last, output ready);
endinterface

### src/ptd_front.sv
// ----------------------------------------------------------------------------
// ptd_front
// Accepts request words, checks the slot range and classifies the command.
// ----------------------------------------------------------------------------
module ptd_front #(
  parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
  ptd_req_if.sink                req,
  input  logic                   q_full,
  output logic                   push,
  output ptd_pkg::op_entry_t     push_data
);

  logic slot_ok;
  logic keep;

  assign slot_ok   = (6'(req.slot) < 6'(NUM_SLOTS));
  assign req.ready = !q_full;

  always_comb begin
    case (req.cmd)
      ptd_pkg::CMD_CREATE:  keep = 1'b1;
      ptd_pkg::CMD_SUSPEND: keep = slot_ok;
      ptd_pkg::CMD_RESUME:  keep = slot_ok;
      ptd_pkg::CMD_DELETE:  keep = slot_ok;
      ptd_pkg::CMD_TICK:    keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign push             = req.valid && req.ready && keep;
  assign push_data.op     = ptd_pkg::cmd_t'(req.cmd);
  assign push_data.ok     = slot_ok;
  assign push_data.slot   = req.slot;
  assign push_data.period = req.period;

endmodule

### src/ptd_queue.sv
// ----------------------------------------------------------------------------
// ptd_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module ptd_queue #(
  parameter int DEPTH = ptd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ptd_pkg::op_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output ptd_pkg::op_entry_t  pop_data,
  output logic                not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptd_pkg::op_entry_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into a full queue");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("pop did not reduce the count");

endmodule

### src/ptd_rem.sv
// ----------------------------------------------------------------------------
// ptd_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptd_rem (
  input  logic               clk,
  input  logic               rst,
  input  ptd_pkg::rem_req_t  req,
  output ptd_pkg::rem_rsp_t  rsp
);

  localparam int W      = ptd_pkg::PERIOD_W;
  localparam int STEP_W = $clog2(W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [W:0]        rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      dvs;
  logic [W:0]        trial;

  assign trial    = {rem[W-1:0], quo[W-1]};
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem  <= (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;
        quo  <= {quo[W-2:0], 1'b0};
        step <= step + 1'b1;
        if (step == STEP_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/ptd_back.sv
// ----------------------------------------------------------------------------
// ptd_back
// Holds the slot table and tick counter, executes commands and walks the slots.
// ----------------------------------------------------------------------------
module ptd_back #(
  parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ptd_pkg::op_entry_t  q_data,
  output logic                q_pop,
  ptd_rsp_if.source           rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int N_W   = $clog2(ptd_pkg::MAX_OUT + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_WAIT, S_ADV, S_EMIT} state_t;

  state_t                         state;
  state_t                         ret;
  logic                           used   [NUM_SLOTS];
  logic                           susp   [NUM_SLOTS];
  logic [ptd_pkg::PERIOD_W-1:0]   period [NUM_SLOTS];
  logic [ptd_pkg::PERIOD_W-1:0]   tick_count;
  logic [IDX_W-1:0]               walk;
  logic [N_W-1:0]                 n;
  logic                           pend_valid;
  logic [IDX_W-1:0]               pend_idx;
  logic                           res_kind;
  logic [ptd_pkg::SLOT_W-1:0]     res_idx;
  logic                           res_err;
  logic                           res_last;
  logic                           out_valid;
  logic                           out_kind;
  logic [ptd_pkg::SLOT_W-1:0]     out_idx;
  logic                           out_err;
  logic                           out_last;

  logic [IDX_W-1:0]               cidx;
  logic [IDX_W-1:0]               rd_idx;
  logic                           rd_used;
  logic                           rd_susp;
  logic [ptd_pkg::PERIOD_W-1:0]   rd_period;
  logic                           create_err;
  logic                           eligible;
  logic                           out_free;
  ptd_pkg::rem_req_t              rem_req;
  ptd_pkg::rem_rsp_t              rem_rsp;

  assign cidx       = IDX_W'(q_data.slot);
  assign rd_idx     = (state == S_IDLE) ? cidx : walk;
  assign rd_used    = used[rd_idx];
  assign rd_susp    = susp[rd_idx];
  assign rd_period  = period[rd_idx];
  assign create_err = !q_data.ok || rd_used;
  assign eligible   = rd_used && !rd_susp && (rd_period != '0);
  assign out_free   = !out_valid || rsp.ready;
  assign q_pop      = (state == S_IDLE) && q_valid;

  assign rem_req.start    = (state == S_CHECK) && eligible;
  assign rem_req.dividend = tick_count;
  assign rem_req.divisor  = rd_period;

  ptd_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign rsp.valid      = out_valid;
  assign rsp.kind       = out_kind;
  assign rsp.task_index = out_idx;
  assign rsp.error      = out_err;
  assign rsp.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      out_valid  <= 1'b0;
      tick_count <= '0;
      walk       <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        used[i]   <= 1'b0;
        susp[i]   <= 1'b0;
        period[i] <= '0;
      end
    end else begin
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_data.op)
              ptd_pkg::CMD_CREATE: begin
                res_kind <= ptd_pkg::KIND_CREATE;
                res_idx  <= q_data.slot;
                res_err  <= create_err;
                res_last <= 1'b1;
                if (!create_err) begin
                  used[cidx]   <= 1'b1;
                  period[cidx] <= q_data.period;
                end
                ret   <= S_IDLE;
                state <= S_EMIT;
              end
              ptd_pkg::CMD_SUSPEND: susp[cidx] <= 1'b1;
              ptd_pkg::CMD_RESUME:  susp[cidx] <= 1'b0;
              ptd_pkg::CMD_DELETE:  used[cidx] <= 1'b0;
              ptd_pkg::CMD_TICK: begin
                tick_count <= tick_count + 1'b1;
                walk       <= '0;
                n          <= '0;
                pend_valid <= 1'b0;
                state      <= S_CHECK;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          state <= eligible ? S_WAIT : S_ADV;
        end
        S_WAIT: begin
          if (rem_rsp.done) begin
            if (rem_rsp.zero) begin
              n          <= n + 1'b1;
              pend_idx   <= walk;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                res_kind <= ptd_pkg::KIND_DISPATCH;
                res_idx  <= ptd_pkg::SLOT_W'(pend_idx);
                res_err  <= 1'b0;
                res_last <= 1'b0;
                ret      <= S_ADV;
                state    <= S_EMIT;
              end else begin
                state <= S_ADV;
              end
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (n == N_W'(ptd_pkg::MAX_OUT) || walk == IDX_W'(NUM_SLOTS - 1)) begin
            pend_valid <= 1'b0;
            if (pend_valid) begin
              res_kind <= ptd_pkg::KIND_DISPATCH;
              res_idx  <= ptd_pkg::SLOT_W'(pend_idx);
              res_err  <= 1'b0;
              res_last <= 1'b1;
              ret      <= S_IDLE;
              state    <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            walk  <= walk + 1'b1;
            state <= S_CHECK;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= res_kind;
            out_idx   <= res_idx;
            out_err   <= res_err;
            out_last  <= res_last;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    n <= N_W'(ptd_pkg::MAX_OUT)) else $error("dispatch count beyond limit");

  a_rem_free: assert property (@(posedge clk) disable iff (rst)
    rem_req.start |-> !rem_rsp.busy) else $error("remainder unit restarted while busy");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid) else $error("pending dispatch left after walk");

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (rem_rsp.busy || rem_rsp.done))
    else $error("waiting on an idle remainder unit");

endmodule

### src/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Task slot table with a periodic tick that dispatches every due slot.
// ----------------------------------------------------------------------------
// A create word is answered by a registered status word; suspend, resume and
// delete only update the slot table in the back end.
// A tick walks the slots in order, runs the bit-serial remainder for each live
// running slot with a nonzero period and sends a dispatch word per due slot.
// A two-word queue lets the front accept during a walk.
// Synchronous reset empties the table, marks slots running, clears the rest.
module periodic_task_dispatcher #(
  parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ptd_req_if.sink     req,
  ptd_rsp_if.source   rsp
);

  logic                q_full;
  logic                q_push;
  ptd_pkg::op_entry_t  q_push_data;
  logic                q_pop;
  ptd_pkg::op_entry_t  q_pop_data;
  logic                q_valid;

  ptd_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  ptd_queue #(.DEPTH(ptd_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  ptd_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
